// File: hw/rtl/cpn_pkg.sv
// Shared widths, register indexes and the divider step for the chromaticity normalizer.
// No dependencies; every other file of the block imports this package.
package cpn_pkg;

  localparam int unsigned PixW     = 8;   // one color channel
  localparam int unsigned SumW     = 10;  // blue + green + red
  localparam int unsigned NumW     = 17;  // 510*x + sum
  localparam int unsigned DenW     = 11;  // 2*sum
  localparam int unsigned ShrW     = 8;   // quotient, one bit per divider stage
  localparam int unsigned CfgDataW = 10;  // widest register
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned DivBits  = ShrW;
  localparam int unsigned ShW      = $clog2(DivBits);
  localparam int unsigned TrialW   = DenW + DivBits;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SUM_THR = 2'd0,
    CFG_RB_THR  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic            qbit;
  } div_step_t;

  // One restoring step: subtract the divisor shifted to the current quotient bit
  function automatic div_step_t div_step(input logic [NumW-1:0] rem,
                                         input logic [DenW-1:0] den,
                                         input logic [ShW-1:0]  sh);
    logic [TrialW-1:0] dsh;
    logic [TrialW-1:0] rem_x;
    div_step_t         res;
    dsh   = {{DivBits{1'b0}}, den} << sh;
    rem_x = {{(TrialW-NumW){1'b0}}, rem};
    if (rem_x >= dsh) begin
      res.rem  = NumW'(rem_x - dsh);
      res.qbit = 1'b1;
    end else begin
      res.rem  = rem;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/cpn_pix_if.sv
// Pixel channel: valid/ready handshake carrying one BGR pixel item.
// Depends on cpn_pkg for the channel width.
interface cpn_pix_if import cpn_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] blue;
  logic [PixW-1:0] green;
  logic [PixW-1:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

// File: hw/rtl/cpn_shr_if.sv
// Share channel: valid/ready handshake carrying the two chromaticity values of an item.
// Depends on cpn_pkg for the share width.
interface cpn_shr_if import cpn_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ShrW-1:0] red_share;
  logic [ShrW-1:0] dominant_share;

  modport source (output valid, output red_share, output dominant_share, input ready);
  modport sink   (input valid, input red_share, input dominant_share, output ready);
endinterface

// File: hw/rtl/chromaticity_pixel_normalizer.sv
// Top level of the chromaticity normalizer: gate, numerator build and an 8-stage divider.
// Depends on cpn_pkg, cpn_pix_if and cpn_shr_if.
//
//   channel   dir   handshake        payload
//   pix_i     in    valid / ready    blue, green, red (8 bit each)
//   shr_o     out   valid / ready    red_share, dominant_share (8 bit each)
//   cfg       in    cfg_we_i         cfg_idx_i (2 bit), cfg_data_i (10 bit)
//
// One item per cycle sustained while shr_o is ready; an item passes the gate stage, the
// numerator stage, then one stage per quotient bit in two parallel restoring dividers.
// Each stage loads when it is empty or its successor moves, so a stall at shr_o
// fills bubbles before it reaches pix_i; nothing is lost or repeated.
// rst_ni clears the stage valid bits and both thresholds to zero.
module chromaticity_pixel_normalizer import cpn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  cpn_pix_if.sink             pix_i,
  cpn_shr_if.source           shr_o
);

  localparam int unsigned NStg = DivBits + 2;

  logic [SumW-1:0] sum_thr_q;
  logic [PixW-1:0] rb_thr_q;

  logic [NStg-1:0] vld_q;
  logic [NStg:0]   stg_rdy;

  // gate stage
  logic [SumW-1:0] g_sum_q;
  logic [PixW-1:0] g_red_q;
  logic [PixW-1:0] g_big_q;
  logic            g_pass_q;
  logic [SumW-1:0] sum_d;
  logic            pass_d;
  logic [PixW-1:0] big_d;

  // numerator stage
  logic [NumW-1:0] n_num_r_q;
  logic [NumW-1:0] n_num_d_q;
  logic [DenW-1:0] n_den_q;
  logic            n_pass_q;

  // divider stages
  logic [NumW-1:0] dv_rem_r_q [DivBits];
  logic [NumW-1:0] dv_rem_d_q [DivBits];
  logic [ShrW-1:0] dv_q_r_q   [DivBits];
  logic [ShrW-1:0] dv_q_d_q   [DivBits];
  logic [DenW-1:0] dv_den_q   [DivBits];
  logic            dv_pass_q  [DivBits];
  div_step_t       st_r       [DivBits];
  div_step_t       st_d       [DivBits];

  // Write the thresholds; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_thr_q <= '0;
      rb_thr_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SUM_THR: sum_thr_q <= cfg_data_i[SumW-1:0];
        CFG_RB_THR:  rb_thr_q  <= cfg_data_i[PixW-1:0];
        default:     ;
      endcase
    end
  end

  // Ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    stg_rdy[NStg] = shr_o.ready;
    for (int k = NStg - 1; k >= 0; k--) begin
      stg_rdy[k] = !vld_q[k] || stg_rdy[k+1];
    end
  end

  assign pix_i.ready = stg_rdy[0];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stg_rdy[0]) begin
        vld_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (stg_rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Gate: channel sum and threshold tests
  always_comb begin
    sum_d  = SumW'(pix_i.blue) + SumW'(pix_i.green) + SumW'(pix_i.red);
    pass_d = (sum_d > sum_thr_q) && ((pix_i.red > rb_thr_q) || (pix_i.blue > rb_thr_q));
    big_d  = (pix_i.red > pix_i.blue) ? pix_i.red : pix_i.blue;
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[0]) begin
      g_sum_q  <= sum_d;
      g_red_q  <= pix_i.red;
      g_big_q  <= big_d;
      g_pass_q <= pass_d;
    end
  end

  // Numerators 510*x + sum and denominator 2*sum
  always_ff @(posedge clk_i) begin
    if (stg_rdy[1]) begin
      n_num_r_q <= ({g_red_q, 9'b0} - {8'b0, g_red_q, 1'b0}) + NumW'(g_sum_q);
      n_num_d_q <= ({g_big_q, 9'b0} - {8'b0, g_big_q, 1'b0}) + NumW'(g_sum_q);
      n_den_q   <= {g_sum_q, 1'b0};
      n_pass_q  <= g_pass_q;
    end
  end

  // One restoring step per stage on the remainders of the stage before
  always_comb begin
    st_r[0] = div_step(n_num_r_q, n_den_q, ShW'(DivBits - 1));
    st_d[0] = div_step(n_num_d_q, n_den_q, ShW'(DivBits - 1));
    for (int j = 1; j < DivBits; j++) begin
      st_r[j] = div_step(dv_rem_r_q[j-1], dv_den_q[j-1], ShW'(DivBits - 1 - j));
      st_d[j] = div_step(dv_rem_d_q[j-1], dv_den_q[j-1], ShW'(DivBits - 1 - j));
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first
  always_ff @(posedge clk_i) begin
    if (stg_rdy[2]) begin
      dv_rem_r_q[0] <= st_r[0].rem;
      dv_rem_d_q[0] <= st_d[0].rem;
      dv_q_r_q[0]   <= {{(ShrW-1){1'b0}}, st_r[0].qbit};
      dv_q_d_q[0]   <= {{(ShrW-1){1'b0}}, st_d[0].qbit};
      dv_den_q[0]   <= n_den_q;
      dv_pass_q[0]  <= n_pass_q;
    end
    for (int j = 1; j < DivBits; j++) begin
      if (stg_rdy[j+2]) begin
        dv_rem_r_q[j] <= st_r[j].rem;
        dv_rem_d_q[j] <= st_d[j].rem;
        dv_q_r_q[j]   <= {dv_q_r_q[j-1][ShrW-2:0], st_r[j].qbit};
        dv_q_d_q[j]   <= {dv_q_d_q[j-1][ShrW-2:0], st_d[j].qbit};
        dv_den_q[j]   <= dv_den_q[j-1];
        dv_pass_q[j]  <= dv_pass_q[j-1];
      end
    end
  end

  // Drive the result; a gated-out pixel gives zero
  assign shr_o.valid          = vld_q[NStg-1];
  assign shr_o.red_share      = dv_pass_q[DivBits-1] ? dv_q_r_q[DivBits-1] : '0;
  assign shr_o.dominant_share = dv_pass_q[DivBits-1] ? dv_q_d_q[DivBits-1] : '0;

  // Larger channel never gives a smaller share
  a_dom_ge_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shr_o.valid |-> (shr_o.dominant_share >= shr_o.red_share))
    else $error("dominant share below red share");

  // Final remainders stay below the divisor for a passing pixel
  a_rem_lt_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NStg-1] && dv_pass_q[DivBits-1]) |->
      ((NumW'(dv_den_q[DivBits-1]) > dv_rem_r_q[DivBits-1]) &&
       (NumW'(dv_den_q[DivBits-1]) > dv_rem_d_q[DivBits-1])))
    else $error("divider remainder not reduced");

  // An accepted pixel lands in the gate stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> vld_q[0])
    else $error("accepted item lost at gate stage");

  // A blocked numerator stage keeps its item
  a_blocked_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[1] && !stg_rdy[2]) |=> vld_q[1])
    else $error("blocked numerator stage dropped its item");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench for chromaticity_pixel_normalizer: BGR pixel items with random gaps and output
// stalls, both shares of each item typed in or predicted and checked in order. Needs cpn_pkg,
// cpn_pix_if, cpn_shr_if and the block's RTL.
module testbench;
  import cpn_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned NumRows       = 24;

  typedef logic [PixW-1:0] chan_t;

  typedef struct packed {
    logic [ShrW-1:0] red_share;
    logic [ShrW-1:0] dominant_share;
  } shares_t;

  // One directed pixel with the thresholds it runs under
  typedef struct packed {
    logic [CfgDataW-1:0] sum_cfg;
    logic [CfgDataW-1:0] rb_cfg;
    chan_t               blue;
    chan_t               green;
    chan_t               red;
    logic                known;   // shares typed in below, else predicted
    shares_t             shares;
  } pixel_row_t;

  localparam pixel_row_t DirectedRows [NumRows] = '{
    // zero sum never passes the gate
    '{10'd0,    10'd0,     8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0}},
    '{10'd0,    10'd0,     8'd255, 8'd255, 8'd255, 1'b1, '{8'd85,  8'd85}},
    '{10'd0,    10'd0,     8'd0,   8'd0,   8'd255, 1'b1, '{8'd255, 8'd255}},
    '{10'd0,    10'd0,     8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd255}},
    // green alone fails the red/blue test
    '{10'd0,    10'd0,     8'd0,   8'd255, 8'd0,   1'b1, '{8'd0,   8'd0}},
    '{10'd0,    10'd0,     8'd0,   8'd0,   8'd1,   1'b1, '{8'd255, 8'd255}},
    // exact half rounds up
    '{10'd0,    10'd0,     8'd0,   8'd1,   8'd1,   1'b1, '{8'd128, 8'd128}},
    '{10'd0,    10'd0,     8'd1,   8'd0,   8'd1,   1'b1, '{8'd128, 8'd128}},
    '{10'd0,    10'd0,     8'hAA,  8'h55,  8'hAA,  1'b1, '{8'd102, 8'd102}},
    '{10'd0,    10'd0,     8'h55,  8'hAA,  8'h55,  1'b1, '{8'd64,  8'd64}},
    // sum threshold at, above and just below the largest reachable sum
    '{10'd765,  10'd0,     8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0}},
    '{10'd1023, 10'd0,     8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0}},
    '{10'd764,  10'd0,     8'd255, 8'd255, 8'd255, 1'b1, '{8'd85,  8'd85}},
    '{10'd0,    10'h0FF,   8'd255, 8'd0,   8'd255, 1'b1, '{8'd0,   8'd0}},
    // upper data bits of the 8-bit register are dropped
    '{10'd0,    10'h3FE,   8'd0,   8'd0,   8'd255, 1'b1, '{8'd255, 8'd255}},
    '{10'd0,    10'h3FE,   8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd255}},
    '{10'd0,    10'd100,   8'd100, 8'd0,   8'd100, 1'b1, '{8'd0,   8'd0}},
    '{10'd0,    10'd100,   8'd100, 8'd50,  8'd101, 1'b0, '{8'd0,   8'd0}},
    '{10'd0,    10'd100,   8'd101, 8'd50,  8'd100, 1'b0, '{8'd0,   8'd0}},
    '{10'd300,  10'd0,     8'd100, 8'd100, 8'd100, 1'b1, '{8'd0,   8'd0}},
    '{10'd300,  10'd0,     8'd100, 8'd101, 8'd100, 1'b0, '{8'd0,   8'd0}},
    '{10'd0,    10'd0,     8'd200, 8'd37,  8'd90,  1'b0, '{8'd0,   8'd0}},
    '{10'd0,    10'd0,     8'd3,   8'd250, 8'd2,   1'b0, '{8'd0,   8'd0}},
    '{10'd512,  10'h200,   8'd255, 8'd128, 8'd255, 1'b0, '{8'd0,   8'd0}}
  };

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  cfg_idx_e            cfg_idx_i  = CFG_SUM_THR;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  cpn_pix_if pix ();
  cpn_shr_if shr ();

  chromaticity_pixel_normalizer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .shr_o      (shr)
  );

  // Thresholds as the block holds them, masked to register width
  logic [SumW-1:0]     sum_limit = '0;
  logic [PixW-1:0]     rb_limit  = '0;
  logic [CfgDataW-1:0] last_sum_cfg = '0;
  logic [CfgDataW-1:0] last_rb_cfg  = '0;

  shares_t     shares_due [$];
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned gated_seen   = 0;
  int unsigned cfg_settings = 0;
  int unsigned idle_cycles  = 0;
  bit          quiet        = 1'b0;
  bit          src_calm     = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gate the pixel, then round 255*x/sum half up in exact integers
  function automatic shares_t predict_shares(chan_t blue, chan_t green, chan_t red);
    int unsigned total;
    int unsigned big;
    shares_t     res;
    total = int'(blue) + int'(green) + int'(red);
    big   = (red > blue) ? int'(red) : int'(blue);
    res   = '0;
    if (total > int'(sum_limit) && (red > rb_limit || blue > rb_limit)) begin
      res.red_share      = ShrW'((510 * int'(red) + total) / (2 * total));
      res.dominant_share = ShrW'((510 * big + total) / (2 * total));
    end
    return res;
  endfunction

  function automatic chan_t clip_chan(int v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return chan_t'(v);
  endfunction

  // Drain the pipeline, then write both thresholds on back-to-back cycles
  task automatic set_thresholds(logic [CfgDataW-1:0] sum_cfg, logic [CfgDataW-1:0] rb_cfg);
    pix.valid <= 1'b0;
    while (shares_due.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SUM_THR;
    cfg_data_i <= sum_cfg;
    @(posedge clk_i);
    sum_limit  = sum_cfg[SumW-1:0];
    cfg_idx_i  <= CFG_RB_THR;
    cfg_data_i <= rb_cfg;
    @(posedge clk_i);
    rb_limit     = rb_cfg[PixW-1:0];
    cfg_we_i     <= 1'b0;
    last_sum_cfg = sum_cfg;
    last_rb_cfg  = rb_cfg;
    cfg_settings++;
  endtask

  // Offer one pixel item, optionally after a gap, and log its shares once accepted
  task automatic push_pixel(chan_t blue, chan_t green, chan_t red, logic known,
                            shares_t typed);
    shares_t want;
    want = known ? typed : predict_shares(blue, green, red);
    if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
    if (!quiet && !src_calm && $urandom_range(0, 5) == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.blue  <= blue;
    pix.green <= green;
    pix.red   <= red;
    do @(posedge clk_i); while (!pix.ready);
    shares_due.push_back(want);
    items_sent++;
  endtask

  initial begin : pixel_source
    pixel_row_t          row;
    int unsigned         n_items;
    logic [CfgDataW-1:0] sum_cfg;
    logic [CfgDataW-1:0] rb_cfg;
    chan_t               b;
    chan_t               g;
    chan_t               r;
    pix.valid = 1'b0;
    pix.blue  = '0;
    pix.green = '0;
    pix.red   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table, rewriting thresholds only when a row changes them
    foreach (DirectedRows[i]) begin
      row = DirectedRows[i];
      if (row.sum_cfg != last_sum_cfg || row.rb_cfg != last_rb_cfg) begin
        set_thresholds(row.sum_cfg, row.rb_cfg);
      end
      push_pixel(row.blue, row.green, row.red, row.known, row.shares);
    end

    // Random phases: extremes first, then random thresholds
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          sum_cfg = '0;
          rb_cfg  = '0;
        end
        1: begin
          sum_cfg = 10'h3FF;
          rb_cfg  = 10'h3FF;
        end
        2: begin
          sum_cfg = 10'd765;
          rb_cfg  = '0;
        end
        3: begin
          sum_cfg = '0;
          rb_cfg  = 10'd255;
        end
        default: begin
          sum_cfg = CfgDataW'($urandom_range(0, 700));
          rb_cfg  = {2'($urandom), 8'($urandom_range(0, 200))};
        end
      endcase
      set_thresholds(sum_cfg, rb_cfg);
      n_items = (p >= 1 && p <= 3) ? 40 : 230;
      quiet   = (p == NumPhases - 1);
      for (int k = 0; k < n_items; k++) begin
        case ($urandom_range(0, 3))
          0: begin
            // tiny channels: small sums and half-way rounding
            b = chan_t'($urandom_range(0, 3));
            g = chan_t'($urandom_range(0, 3));
            r = chan_t'($urandom_range(0, 3));
          end
          1: begin
            // straddle both gate thresholds
            if ($urandom_range(0, 1) == 0) begin
              r = clip_chan(int'(rb_limit) - 1 + int'($urandom_range(0, 2)));
              b = chan_t'($urandom);
            end else begin
              b = clip_chan(int'(rb_limit) - 1 + int'($urandom_range(0, 2)));
              r = chan_t'($urandom);
            end
            g = clip_chan(int'(sum_limit) - int'(r) - int'(b) - 1
                          + int'($urandom_range(0, 2)));
          end
          default: begin
            b = chan_t'($urandom);
            g = chan_t'($urandom);
            r = chan_t'($urandom);
          end
        endcase
        push_pixel(b, g, r, 1'b0, '0);
      end
    end

    // Drop valid, wait for every share item, then hold a little longer
    pix.valid <= 1'b0;
    while (shares_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d directed rows and %0d threshold settings incl. extremes",
             NumRows, cfg_settings);
    $display("sent %0d pixel items, checked %0d share items, %0d of them gated to zero",
             items_sent, results_seen, gated_seen);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Accept share items with random stall bursts and compare with the oldest prediction
  initial begin : share_sink
    int unsigned stall_left;
    bit          sink_calm;
    shares_t     want;
    stall_left = 0;
    sink_calm  = 1'b0;
    shr.ready  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (shr.valid && shr.ready) begin
        if (shares_due.size() == 0) begin
          $error("share item with nothing pending: red_share %0d, dominant_share %0d",
                 shr.red_share, shr.dominant_share);
          mismatches++;
        end else begin
          want = shares_due.pop_front();
          if (shr.red_share !== want.red_share) begin
            $error("red_share: expected %0d, got %0d", want.red_share, shr.red_share);
            mismatches++;
          end
          if (shr.dominant_share !== want.dominant_share) begin
            $error("dominant_share: expected %0d, got %0d",
                   want.dominant_share, shr.dominant_share);
            mismatches++;
          end
          results_seen++;
          if (want == '0) gated_seen++;
        end
      end
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
      if (stall_left == 0 && !quiet && !sink_calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left != 0) begin
        shr.ready <= 1'b0;
        stall_left--;
      end else begin
        shr.ready <= 1'b1;
      end
    end
  end

  // Count cycles in which neither channel moves an item
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (shr.valid && shr.ready)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
    end
  end

  initial begin : watchdog
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
